// ===== sv/triangle_translate_and_area_unit_assert.svh =====
// Assertion macros for the triangle unit top level.
`ifndef TRIANGLE_TRANSLATE_AND_AREA_UNIT_ASSERT_SVH
`define TRIANGLE_TRANSLATE_AND_AREA_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define TAU_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tau assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define TAU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tau assertion failed");
`else
`define TAU_ASSERT_NOW(label, clk, rstn, ante, cons)
`define TAU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/tau_pkg.sv =====
// Shared types and codes of the triangle translate and area unit.
`timescale 1ns / 1ps
package tau_pkg;

    // Fixed port widths.
    localparam int IN_COORD_W = 12;
    localparam int AREA_W     = 32;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD      = 2'd0;
    localparam logic [1:0] KIND_TRANSLATE = 2'd1;
    localparam logic [1:0] KIND_AREA      = 2'd2;

    // Axis character codes.
    localparam logic [7:0] AXIS_CODE_X = 8'd120;
    localparam logic [7:0] AXIS_CODE_Y = 8'd121;
    localparam logic [7:0] AXIS_CODE_Z = 8'd122;

    // Result status codes.
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_AXIS   = 2'd1;
    localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

    typedef enum logic [1:0] {
        AXIS_SEL_X,
        AXIS_SEL_Y,
        AXIS_SEL_Z
    } tau_axis_t;

    // Command from the control to the vertex store.
    typedef struct packed {
        logic      load;
        logic      translate;
        logic [1:0] index;
        tau_axis_t axis;
    } tau_vcmd_t;

    // Status of the area engine.
    typedef struct packed {
        logic busy;
        logic done;
    } tau_eng_sts_t;

endpackage

// ===== sv/tau_vertex_store.sv =====
// Vertex registers with load and saturating translate.
`timescale 1ns / 1ps
module tau_vertex_store import tau_pkg::*; #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tau_vcmd_t                     cmd,
    input  logic signed [IN_COORD_W-1:0]  load_x,
    input  logic signed [IN_COORD_W-1:0]  load_y,
    input  logic signed [IN_COORD_W-1:0]  load_z,
    input  logic signed [IN_COORD_W-1:0]  distance,
    output logic signed [COORD_WIDTH-1:0] vert_x [3],
    output logic signed [COORD_WIDTH-1:0] vert_y [3],
    output logic signed [COORD_WIDTH-1:0] vert_z [3],
    output logic [2:0]                    loaded
);

    localparam int SUM_W = IN_COORD_W + 1;
    localparam logic signed [SUM_W-1:0] C_HI = SUM_W'((1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [SUM_W-1:0] C_LO = SUM_W'(-(1 <<< (COORD_WIDTH - 1)));

    logic signed [COORD_WIDTH-1:0] x_reg [3];
    logic signed [COORD_WIDTH-1:0] y_reg [3];
    logic signed [COORD_WIDTH-1:0] z_reg [3];
    logic [2:0]                    loaded_reg;

    // Saturate a wide value to the coordinate range.
    function automatic logic signed [COORD_WIDTH-1:0] clamp_f(
        input logic signed [SUM_W-1:0] s
    );
        logic signed [SUM_W-1:0] r;
        r = s;
        if (s > C_HI) begin
            r = C_HI;
        end else if (s < C_LO) begin
            r = C_LO;
        end
        return r[COORD_WIDTH-1:0];
    endfunction

    // Load writes one vertex; translate moves one axis of every loaded vertex.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                x_reg[i] <= '0;
                y_reg[i] <= '0;
                z_reg[i] <= '0;
            end
            loaded_reg <= '0;
        end else if (cmd.load) begin
            for (int i = 0; i < 3; i++) begin
                if (cmd.index == 2'(i)) begin
                    x_reg[i]      <= clamp_f(SUM_W'(load_x));
                    y_reg[i]      <= clamp_f(SUM_W'(load_y));
                    z_reg[i]      <= clamp_f(SUM_W'(load_z));
                    loaded_reg[i] <= 1'b1;
                end
            end
        end else if (cmd.translate) begin
            for (int i = 0; i < 3; i++) begin
                if (loaded_reg[i]) begin
                    case (cmd.axis)
                        AXIS_SEL_X: x_reg[i] <= clamp_f(SUM_W'(x_reg[i]) + SUM_W'(distance));
                        AXIS_SEL_Y: y_reg[i] <= clamp_f(SUM_W'(y_reg[i]) + SUM_W'(distance));
                        AXIS_SEL_Z: z_reg[i] <= clamp_f(SUM_W'(z_reg[i]) + SUM_W'(distance));
                        default: ;
                    endcase
                end
            end
        end
    end

    assign vert_x = x_reg;
    assign vert_y = y_reg;
    assign vert_z = z_reg;
    assign loaded = loaded_reg;

endmodule

// ===== sv/tau_area_engine.sv =====
// Area engine: one shared multiplier for the cross product and its squared
// magnitude, then a two-bits-per-cycle integer square root.
`timescale 1ns / 1ps
module tau_area_engine import tau_pkg::*; #(
    parameter int COORD_WIDTH    = 12,
    parameter int AREA_FRAC_BITS = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [COORD_WIDTH-1:0] vert_x [3],
    input  logic signed [COORD_WIDTH-1:0] vert_y [3],
    input  logic signed [COORD_WIDTH-1:0] vert_z [3],
    output tau_eng_sts_t                  sts,
    output logic [AREA_W-1:0]             area
);

    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int CROSS_W = 2 * DIFF_W + 1;
    localparam int MAG_W   = 2 * CROSS_W;
    localparam int SHIFT   = (AREA_FRAC_BITS == 0) ? 0 : 2 * AREA_FRAC_BITS - 2;
    localparam int RAD_W   = MAG_W + SHIFT;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int NIT     = RAD_W / 2;
    localparam int CNT_W   = $clog2(NIT);
    localparam logic [3:0] LAST_STEP = 4'd9;

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_PREP,
        E_SQRT
    } eng_state_t;

    eng_state_t state_reg;
    logic       done_reg;
    logic [3:0] step_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, uz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [CROSS_W-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [MAG_W-1:0]   prod_reg;
    logic [MAG_W-1:0]          mag_reg;
    logic [RAD_W-1:0]          rad_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [AREA_W-1:0]         area_reg;

    logic signed [CROSS_W-1:0] op_a, op_b;
    logic [REM_W+1:0]          rem_sh;
    logic [REM_W+1:0]          trial;
    logic [ROOT_W-1:0]         root_next;
    logic [REM_W-1:0]          rem_next;

    // Operand select for the shared multiplier.
    always_comb begin
        case (step_reg)
            4'd0: begin op_a = CROSS_W'(uy_reg); op_b = CROSS_W'(wz_reg); end
            4'd1: begin op_a = CROSS_W'(uz_reg); op_b = CROSS_W'(wy_reg); end
            4'd2: begin op_a = CROSS_W'(uz_reg); op_b = CROSS_W'(wx_reg); end
            4'd3: begin op_a = CROSS_W'(ux_reg); op_b = CROSS_W'(wz_reg); end
            4'd4: begin op_a = CROSS_W'(ux_reg); op_b = CROSS_W'(wy_reg); end
            4'd5: begin op_a = CROSS_W'(uy_reg); op_b = CROSS_W'(wx_reg); end
            4'd6: begin op_a = cx_reg; op_b = cx_reg; end
            4'd7: begin op_a = cy_reg; op_b = cy_reg; end
            4'd8: begin op_a = cz_reg; op_b = cz_reg; end
            default: begin op_a = '0; op_b = '0; end
        endcase
    end

    // One digit of the square root: bring down two radicand bits and try.
    always_comb begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        if (rem_sh >= trial) begin
            rem_next  = REM_W'(rem_sh - trial);
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end else begin
            rem_next  = rem_sh[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    // Sequencer and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                E_IDLE: begin
                    if (start) begin
                        ux_reg    <= DIFF_W'(vert_x[1]) - DIFF_W'(vert_x[0]);
                        uy_reg    <= DIFF_W'(vert_y[1]) - DIFF_W'(vert_y[0]);
                        uz_reg    <= DIFF_W'(vert_z[1]) - DIFF_W'(vert_z[0]);
                        wx_reg    <= DIFF_W'(vert_x[2]) - DIFF_W'(vert_x[0]);
                        wy_reg    <= DIFF_W'(vert_y[2]) - DIFF_W'(vert_y[0]);
                        wz_reg    <= DIFF_W'(vert_z[2]) - DIFF_W'(vert_z[0]);
                        step_reg  <= '0;
                        state_reg <= E_MUL;
                    end
                end
                E_MUL: begin
                    // Multiply this step and fold the previous product into the cross product or magnitude.
                    prod_reg <= op_a * op_b;
                    case (step_reg)
                        4'd1: cx_reg  <= $signed(prod_reg[CROSS_W-1:0]);
                        4'd2: cx_reg  <= cx_reg - $signed(prod_reg[CROSS_W-1:0]);
                        4'd3: cy_reg  <= $signed(prod_reg[CROSS_W-1:0]);
                        4'd4: cy_reg  <= cy_reg - $signed(prod_reg[CROSS_W-1:0]);
                        4'd5: cz_reg  <= $signed(prod_reg[CROSS_W-1:0]);
                        4'd6: cz_reg  <= cz_reg - $signed(prod_reg[CROSS_W-1:0]);
                        4'd7: mag_reg <= $unsigned(prod_reg);
                        4'd8: mag_reg <= mag_reg + $unsigned(prod_reg);
                        4'd9: mag_reg <= mag_reg + $unsigned(prod_reg);
                        default: ;
                    endcase
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == LAST_STEP) begin
                        state_reg <= E_PREP;
                    end
                end
                E_PREP: begin
                    rad_reg   <= RAD_W'(mag_reg) << SHIFT;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    cnt_reg   <= '0;
                    state_reg <= E_SQRT;
                end
                E_SQRT: begin
                    rad_reg  <= rad_reg << 2;
                    rem_reg  <= rem_next;
                    root_reg <= root_next;
                    cnt_reg  <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(NIT - 1)) begin
                        if (AREA_FRAC_BITS == 0) begin
                            area_reg <= AREA_W'(root_next >> 1);
                        end else begin
                            area_reg <= AREA_W'(root_next);
                        end
                        done_reg  <= 1'b1;
                        state_reg <= E_IDLE;
                    end
                end
                default: state_reg <= E_IDLE;
            endcase
        end
    end

    assign sts.busy = (state_reg != E_IDLE);
    assign sts.done = done_reg;
    assign area     = area_reg;

endmodule

// ===== sv/triangle_translate_and_area_unit.sv =====
// Top level of the triangle translate and area unit.
//
//  Channel | Ports                                  | Direction | Handshake
//  --------+----------------------------------------+-----------+----------------
//  input   | s_kind .. s_axis_code                  | in        | s_valid/s_ready
//  result  | m_status, m_area_q4                    | out       | m_valid/m_ready
//
// Load and translate items give their result one cycle after the transfer.
// An area item with all vertices loaded runs the cross product and its squared
// magnitude on the shared multiplier, then the square root one digit per cycle.
// One item is in work at a time; s_ready is low while an area item runs.
// While a result waits, s_ready follows m_ready, so a new item transfers with it.
// Reset is synchronous on aresetn low and clears all vertices and loaded flags.
`timescale 1ns / 1ps
`include "triangle_translate_and_area_unit_assert.svh"
module triangle_translate_and_area_unit import tau_pkg::*; #(
    parameter int COORD_WIDTH    = 12,
    parameter int AREA_FRAC_BITS = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_kind,
    input  logic [1:0]                   s_vertex_index,
    input  logic signed [IN_COORD_W-1:0] s_x_value,
    input  logic signed [IN_COORD_W-1:0] s_y_value,
    input  logic signed [IN_COORD_W-1:0] s_z_value,
    input  logic signed [IN_COORD_W-1:0] s_distance,
    input  logic [7:0]                   s_axis_code,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [AREA_W-1:0]            m_area_q4
);

    typedef enum logic {
        ST_IDLE,
        ST_WAIT
    } top_state_t;

    top_state_t state_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [AREA_W-1:0] m_area_reg;

    logic              in_xfer;
    logic              axis_ok;
    tau_axis_t         axis_sel;
    logic              all_loaded;
    logic              area_start;
    logic [1:0]        status_now;
    tau_vcmd_t         vcmd;
    tau_eng_sts_t      eng_sts;
    logic [AREA_W-1:0] eng_area;
    logic [2:0]        loaded;

    logic signed [COORD_WIDTH-1:0] vert_x [3];
    logic signed [COORD_WIDTH-1:0] vert_y [3];
    logic signed [COORD_WIDTH-1:0] vert_z [3];

    // Take a new item only when no area item runs and the result slot frees.
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer = s_valid && s_ready;

    // Axis character decode.
    always_comb begin
        case (s_axis_code)
            AXIS_CODE_X: begin axis_ok = 1'b1; axis_sel = AXIS_SEL_X; end
            AXIS_CODE_Y: begin axis_ok = 1'b1; axis_sel = AXIS_SEL_Y; end
            AXIS_CODE_Z: begin axis_ok = 1'b1; axis_sel = AXIS_SEL_Z; end
            default:     begin axis_ok = 1'b0; axis_sel = AXIS_SEL_X; end
        endcase
    end

    assign all_loaded = &loaded;
    assign area_start = in_xfer && (s_kind == KIND_AREA) && all_loaded;

    // Immediate status for items that do not start the area engine.
    always_comb begin
        status_now = STATUS_OK;
        if (s_kind == KIND_TRANSLATE && !axis_ok) begin
            status_now = STATUS_BAD_AXIS;
        end else if (s_kind == KIND_AREA && !all_loaded) begin
            status_now = STATUS_INCOMPLETE;
        end
    end

    // Vertex store command.
    always_comb begin
        vcmd.load      = in_xfer && (s_kind == KIND_LOAD)
                         && (s_vertex_index inside {2'd0, 2'd1, 2'd2});
        vcmd.translate = in_xfer && (s_kind == KIND_TRANSLATE) && axis_ok;
        vcmd.index     = s_vertex_index;
        vcmd.axis      = axis_sel;
    end

    tau_vertex_store #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (vcmd),
        .load_x   (s_x_value),
        .load_y   (s_y_value),
        .load_z   (s_z_value),
        .distance (s_distance),
        .vert_x   (vert_x),
        .vert_y   (vert_y),
        .vert_z   (vert_z),
        .loaded   (loaded)
    );

    tau_area_engine #(
        .COORD_WIDTH    (COORD_WIDTH),
        .AREA_FRAC_BITS (AREA_FRAC_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (area_start),
        .vert_x  (vert_x),
        .vert_y  (vert_y),
        .vert_z  (vert_z),
        .sts     (eng_sts),
        .area    (eng_area)
    );

    // Control state and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (m_valid_reg && m_ready) begin
                        m_valid_reg <= 1'b0;
                    end
                    if (area_start) begin
                        state_reg <= ST_WAIT;
                    end else if (in_xfer) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_now;
                        m_area_reg   <= '0;
                    end
                end
                ST_WAIT: begin
                    if (eng_sts.done) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= STATUS_OK;
                        m_area_reg   <= eng_area;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_area_q4 = m_area_reg;

    // The engine only finishes while the control waits for it.
    `TAU_ASSERT_NOW(a_done_in_wait, aclk, aresetn, eng_sts.done, state_reg == ST_WAIT)
    // A started area item keeps the engine busy in the next cycle.
    `TAU_ASSERT_NEXT(a_start_busy, aclk, aresetn, area_start, eng_sts.busy)
    // No result is shown while an area item is still in work.
    `TAU_ASSERT_NOW(a_wait_no_result, aclk, aresetn, state_reg == ST_WAIT, !m_valid_reg)
    // A nonzero area only comes with status ok.
    `TAU_ASSERT_NOW(a_area_ok, aclk, aresetn, m_valid_reg && (m_area_reg != '0),
                    m_status_reg == STATUS_OK)

endmodule

// ===== tb/tb_triangle_translate_and_area_unit.sv =====
// Self-checking testbench for the triangle translate and area unit.
`timescale 1ns / 1ps
module tb_triangle_translate_and_area_unit import tau_pkg::*;;

    localparam int CW          = 12;
    localparam int FB          = 4;
    localparam int N_RANDOM    = 1300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    // Codes that the package leaves unnamed: the spare kind and the spare vertex slot.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] VIDX_NONE   = 2'd3;

    localparam logic signed [IN_COORD_W-1:0] COORD_MAX = {1'b0, {(IN_COORD_W-1){1'b1}}};
    localparam logic signed [IN_COORD_W-1:0] COORD_MIN = {1'b1, {(IN_COORD_W-1){1'b0}}};
    localparam longint SAT_HI = (longint'(1) << (CW - 1)) - 1;
    localparam longint SAT_LO = -(longint'(1) << (CW - 1));

    typedef struct {
        logic [1:0]                   kind;
        logic [1:0]                   vidx;
        logic signed [IN_COORD_W-1:0] x;
        logic signed [IN_COORD_W-1:0] y;
        logic signed [IN_COORD_W-1:0] z;
        logic signed [IN_COORD_W-1:0] delta;
        logic [7:0]                   axis;
    } tri_cmd_t;

    typedef struct {
        logic [1:0]        status;
        logic [AREA_W-1:0] area_q4;
    } tri_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic m_ready = 1'b0;
    logic s_ready;
    logic m_valid;
    logic [1:0] m_status;
    logic [AREA_W-1:0] m_area_q4;

    tri_cmd_t held = '{default: '0};

    // Commands waiting to be offered and results owed by the unit, oldest first.
    tri_cmd_t    cmd_queue[$];
    tri_result_t area_status_due[$];

    // Shadow copy of the vertex store.
    logic signed [IN_COORD_W-1:0] vx [3];
    logic signed [IN_COORD_W-1:0] vy [3];
    logic signed [IN_COORD_W-1:0] vz [3];
    logic [2:0] vloaded;

    int planned;
    int cmd_total;
    int accepted;
    int results_seen;
    int mismatches;
    int n_load, n_translate, n_area, n_noop;
    int n_area_done, n_incomplete, n_bad_axis, n_sat;

    int unsigned cycles = 0;
    logic        calm = 1'b0;
    logic [15:0] stall_pat = 16'hB6D3;
    int          burst_left = 0;
    int          gap_left = 0;

    triangle_translate_and_area_unit #(
        .COORD_WIDTH    (CW),
        .AREA_FRAC_BITS (FB)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (held.kind),
        .s_vertex_index (held.vidx),
        .s_x_value      (held.x),
        .s_y_value      (held.y),
        .s_z_value      (held.z),
        .s_distance     (held.delta),
        .s_axis_code    (held.axis),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_area_q4      (m_area_q4)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic signed [IN_COORD_W-1:0] sat_coord(input longint v);
        if (v > SAT_HI) v = SAT_HI;
        if (v < SAT_LO) v = SAT_LO;
        return IN_COORD_W'(v);
    endfunction

    // Adds a distance to one coordinate and notes when the sum had to be clipped.
    function automatic logic signed [IN_COORD_W-1:0] moved(
        input logic signed [IN_COORD_W-1:0] p,
        input logic signed [IN_COORD_W-1:0] d
    );
        longint s;
        s = longint'(p) + longint'(d);
        if (s > SAT_HI || s < SAT_LO) n_sat++;
        return sat_coord(s);
    endfunction

    // Digit-by-digit integer square root, floor of the exact root.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Half the cross-product magnitude of edges from the first vertex, in fixed point.
    function automatic logic [AREA_W-1:0] tri_area_q4();
        longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
        longint unsigned mag2;
        ux = longint'(vx[1]) - longint'(vx[0]);
        uy = longint'(vy[1]) - longint'(vy[0]);
        uz = longint'(vz[1]) - longint'(vz[0]);
        wx = longint'(vx[2]) - longint'(vx[0]);
        wy = longint'(vy[2]) - longint'(vy[0]);
        wz = longint'(vz[2]) - longint'(vz[0]);
        cx = uy * wz - uz * wy;
        cy = uz * wx - ux * wz;
        cz = ux * wy - uy * wx;
        mag2 = cx * cx + cy * cy + cz * cz;
        if (FB == 0) return AREA_W'(int_sqrt(mag2) >> 1);
        return AREA_W'(int_sqrt(mag2 << (2 * FB - 2)));
    endfunction

    // Applies one accepted command to the shadow store and records the result it owes.
    function automatic void triangle_step(input tri_cmd_t c);
        tri_result_t r;
        r.status  = STATUS_OK;
        r.area_q4 = '0;
        case (c.kind)
            KIND_LOAD: begin
                n_load++;
                if (c.vidx != VIDX_NONE) begin
                    vx[c.vidx] = sat_coord(longint'(c.x));
                    vy[c.vidx] = sat_coord(longint'(c.y));
                    vz[c.vidx] = sat_coord(longint'(c.z));
                    vloaded[c.vidx] = 1'b1;
                end
            end
            KIND_TRANSLATE: begin
                n_translate++;
                if (c.axis != AXIS_CODE_X && c.axis != AXIS_CODE_Y && c.axis != AXIS_CODE_Z) begin
                    r.status = STATUS_BAD_AXIS;
                    n_bad_axis++;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        if (vloaded[i]) begin
                            if (c.axis == AXIS_CODE_X) vx[i] = moved(vx[i], c.delta);
                            else if (c.axis == AXIS_CODE_Y) vy[i] = moved(vy[i], c.delta);
                            else vz[i] = moved(vz[i], c.delta);
                        end
                    end
                end
            end
            KIND_AREA: begin
                n_area++;
                if (vloaded != 3'b111) begin
                    r.status = STATUS_INCOMPLETE;
                    n_incomplete++;
                end else begin
                    r.area_q4 = tri_area_q4();
                    n_area_done++;
                end
            end
            default: begin
                n_noop++;
            end
        endcase
        area_status_due.push_back(r);
    endfunction

    // Coordinates lean toward the range limits and toward small values.
    function automatic logic signed [IN_COORD_W-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2, 3: begin
                v = int'($urandom_range(0, 16)) - 8;
                return IN_COORD_W'(v);
            end
            default: return IN_COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 2))
            0: return AXIS_CODE_X;
            1: return AXIS_CODE_Y;
            default: return AXIS_CODE_Z;
        endcase
    endfunction

    task automatic queue_cmd(
        input logic [1:0] k,
        input logic [1:0] vi,
        input logic signed [IN_COORD_W-1:0] xv,
        input logic signed [IN_COORD_W-1:0] yv,
        input logic signed [IN_COORD_W-1:0] zv,
        input logic signed [IN_COORD_W-1:0] dv,
        input logic [7:0] ax
    );
        tri_cmd_t c;
        c = '{kind: k, vidx: vi, x: xv, y: yv, z: zv, delta: dv, axis: ax};
        cmd_queue.push_back(c);
        // No-ops and loads to the spare slot do not count toward the random budget.
        if (!(k == KIND_UNUSED || (k == KIND_LOAD && vi == VIDX_NONE))) planned++;
    endtask

    // Three loads, up to three moves, an area query, at times one more move and query.
    task automatic queue_triangle();
        int first;
        int moves;
        logic flat;
        logic signed [IN_COORD_W-1:0] ax0, ay0, az0;
        first = $urandom_range(0, 2);
        flat  = ($urandom_range(0, 7) == 0);
        ax0 = pick_coord();
        ay0 = pick_coord();
        az0 = pick_coord();
        queue_cmd(KIND_LOAD, 2'(first), ax0, ay0, az0, pick_coord(), 8'($urandom));
        queue_cmd(KIND_LOAD, 2'((first + 1) % 3), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), 8'($urandom));
        // Occasionally repeat a vertex so the triangle collapses.
        if (flat) begin
            queue_cmd(KIND_LOAD, 2'((first + 2) % 3), ax0, ay0, az0, pick_coord(), 8'($urandom));
        end else begin
            queue_cmd(KIND_LOAD, 2'((first + 2) % 3), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), 8'($urandom));
        end
        moves = $urandom_range(0, 3);
        repeat (moves) begin
            queue_cmd(KIND_TRANSLATE, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_axis());
        end
        queue_cmd(KIND_AREA, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                  pick_coord(), 8'($urandom));
        if ($urandom_range(0, 2) == 0) begin
            queue_cmd(KIND_TRANSLATE, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_axis());
            queue_cmd(KIND_AREA, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), 8'($urandom));
        end
    endtask

    task automatic build_directed();
        // Empty store: area is incomplete, a move touches nothing, bad axis still flagged.
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd100, AXIS_CODE_X);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd5, 8'd0);
        queue_cmd(KIND_UNUSED, 2'd1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 8'hFF);
        queue_cmd(KIND_LOAD, VIDX_NONE, 12'sd7, 12'sd7, 12'sd7, 0, AXIS_CODE_Y);
        // Widest triangle, with the area asked once before the last vertex arrives.
        queue_cmd(KIND_LOAD, 2'd0, COORD_MIN, COORD_MIN, COORD_MIN, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd1, COORD_MAX, COORD_MIN, COORD_MAX, 0, 8'd0);
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd2, COORD_MIN, COORD_MAX, COORD_MAX, 0, 8'd0);
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
        // Moves that clip at the top of the range on X and Z and at the bottom on Y.
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, COORD_MAX, AXIS_CODE_X);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, COORD_MIN, AXIS_CODE_Y);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd1, AXIS_CODE_Z);
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
        // Axis bytes just outside the legal codes and at the top byte limit.
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd3, 8'hFF);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd3, AXIS_CODE_X - 8'd1);
        queue_cmd(KIND_TRANSLATE, 2'd0, 0, 0, 0, 12'sd3, AXIS_CODE_Z + 8'd1);
        // Degenerate triangle with all vertices on one point.
        queue_cmd(KIND_LOAD, 2'd0, 12'sd5, 12'sd5, 12'sd5, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd1, 12'sd5, 12'sd5, 12'sd5, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd2, 12'sd5, 12'sd5, 12'sd5, 0, 8'd0);
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
        // Unit right triangle, where the half lands in the fraction bits.
        queue_cmd(KIND_LOAD, 2'd0, 0, 0, 0, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd1, 12'sd1, 0, 0, 0, 8'd0);
        queue_cmd(KIND_LOAD, 2'd2, 0, 12'sd1, 0, 0, 8'd0);
        queue_cmd(KIND_AREA, 2'd0, 0, 0, 0, 0, 8'd0);
    endtask

    task automatic build_random();
        int start;
        int r;
        start = planned;
        while (planned - start < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                queue_triangle();
            end else if (r < 80) begin
                queue_cmd(KIND_LOAD, 2'($urandom_range(0, 2)), pick_coord(), pick_coord(),
                          pick_coord(), pick_coord(), 8'($urandom));
            end else if (r < 88) begin
                queue_cmd(KIND_TRANSLATE, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), $urandom_range(0, 1) ? pick_axis() : 8'($urandom));
            end else if (r < 93) begin
                queue_cmd(KIND_AREA, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), 8'($urandom));
            end else if ($urandom_range(0, 1) == 0) begin
                queue_cmd(KIND_UNUSED, 2'($urandom), pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), 8'($urandom));
            end else begin
                queue_cmd(KIND_LOAD, VIDX_NONE, pick_coord(), pick_coord(), pick_coord(),
                          pick_coord(), 8'($urandom));
            end
        end
    endtask

    // Cycle count, timeout, and the receiver's stall pattern with calm stretches.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t ns: timeout after %0d cycles", $time, cycles);
            $display("tb_triangle_translate_and_area_unit: done, errors");
            $finish;
        end else begin
            if (cycles[7:0] == 8'hFF) begin
                calm      <= ($urandom_range(0, 3) == 0);
                stall_pat <= 16'($urandom) | 16'h0001;
            end
            m_ready <= calm || stall_pat[cycles[3:0]];
        end
    end

    // Sender: offers queued commands in bursts, with gaps between bursts.
    always @(posedge aclk) begin : feed
        logic fire;
        fire = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (fire) begin
                triangle_step(held);
                accepted++;
            end
            if (!s_valid || fire) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    held    <= cmd_queue.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= calm ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result checker: each result transfer is matched against the oldest one owed.
    always @(posedge aclk) begin : check
        tri_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (area_status_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got status %0d area %0d",
                         $time, m_status, m_area_q4);
                mismatches++;
            end else begin
                want = area_status_due.pop_front();
                results_seen++;
                if (m_status !== want.status) begin
                    $display("%0t ns: status mismatch, expected %0d, got %0d",
                             $time, want.status, m_status);
                    mismatches++;
                end
                if (m_area_q4 !== want.area_q4) begin
                    $display("%0t ns: area mismatch, expected %0d, got %0d",
                             $time, want.area_q4, m_area_q4);
                    mismatches++;
                end
            end
        end
    end

    initial begin : run
        for (int i = 0; i < 3; i++) begin
            vx[i] = '0;
            vy[i] = '0;
            vz[i] = '0;
        end
        vloaded = '0;
        build_directed();
        build_random();
        cmd_total = cmd_queue.size();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        // Wait for every command to transfer, then for every owed result.
        while (accepted != cmd_total) @(posedge aclk);
        while (area_status_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("Covered %0d commands: %0d loads, %0d moves, %0d area queries, %0d no-ops.",
                 accepted, n_load, n_translate, n_area, n_noop);
        $display("Checked %0d results: %0d areas, %0d incomplete, %0d bad axis, %0d clipped.",
                 results_seen, n_area_done, n_incomplete, n_bad_axis, n_sat);
        if (mismatches == 0) begin
            $display("tb_triangle_translate_and_area_unit: done, clean");
        end else begin
            $display("tb_triangle_translate_and_area_unit: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tau_pkg.sv
sv/tau_vertex_store.sv
sv/tau_area_engine.sv
sv/triangle_translate_and_area_unit.sv
tb/tb_triangle_translate_and_area_unit.sv
